// File: rtl/bdms_pkg.sv
// Package for the button debounce and mode selector: mode codes, register
// indexes, widths, reset values and the short-press step function.
// No dependencies.
package bdms_pkg;

  localparam int unsigned TIME_W     = 32;
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned CFG_IDX_W  = 8;

  localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd20;
  localparam logic [CFG_W-1:0] HOLD_RESET     = 16'd1000;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD     = 8'd1;

  typedef enum logic [1:0] {
    MODE_MUTE = 2'd0,
    MODE_PLAY = 2'd1,
    MODE_EDIT = 2'd2,
    MODE_REC  = 2'd3
  } mode_t;

  // Debounce and mode state carried from one sample to the next.
  typedef struct packed {
    logic              stable_level;
    logic [TIME_W-1:0] change_time;
    logic [TIME_W-1:0] press_start;
    mode_t             active_mode;
  } bdms_state_t;

  function automatic mode_t short_press_next(input mode_t m);
    mode_t r;
    unique case (m)
      MODE_MUTE: r = MODE_PLAY;
      MODE_PLAY: r = MODE_EDIT;
      MODE_EDIT: r = MODE_PLAY;
      MODE_REC:  r = MODE_REC;
      default:   r = m;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/bdms_step.sv
// Next-state logic for one pin sample: debounce, press timing and mode step.
// Depends on bdms_pkg.
module bdms_step
  import bdms_pkg::*;
(
  input  bdms_state_t       state,
  input  logic              pin_level,
  input  logic [TIME_W-1:0] now_ms,
  input  logic [CFG_W-1:0]  debounce_ms,
  input  logic [CFG_W-1:0]  hold_ms,
  output bdms_state_t       state_next
);

  logic [TIME_W-1:0] since_change;
  logic [TIME_W-1:0] since_press;
  logic              settled;
  logic              level;
  logic              rise;
  logic              fall;
  logic              held;
  mode_t             mode_step;

  always_comb begin
    since_change = now_ms - state.change_time;
    settled      = since_change > {{(TIME_W-CFG_W){1'b0}}, debounce_ms};

    state_next = state;
    if (pin_level != state.stable_level) begin
      if (settled) begin
        state_next.stable_level = pin_level;
        state_next.change_time  = now_ms;
      end
    end else begin
      state_next.change_time = now_ms;
    end

    level = state_next.stable_level;
    rise  = level & ~state.stable_level;
    fall  = ~level & state.stable_level;

    // On a rising edge the press starts now, so the elapsed time is zero.
    since_press = rise ? '0 : (now_ms - state.press_start);
    held        = since_press >= {{(TIME_W-CFG_W){1'b0}}, hold_ms};
    if (rise) begin
      state_next.press_start = now_ms;
    end

    mode_step = state.active_mode;
    if (fall && !held) begin
      mode_step = short_press_next(mode_step);
    end
    if (level && mode_step != MODE_REC && held) begin
      mode_step = MODE_REC;
    end
    if (!level && mode_step == MODE_REC) begin
      mode_step = MODE_PLAY;
    end
    state_next.active_mode = mode_step;
  end

endmodule

// File: rtl/button_debounce_mode_selector_unit.sv
// Top level of the button debounce and mode selector.
// Depends on bdms_pkg and bdms_step.
//
// Usage: each input transaction carries one sample of the mode button pin
// (pin_level) with its millisecond timestamp (now_ms). Every input
// transaction yields exactly one output transaction with the debounced level
// (pressed) and the sequencer mode (mode: MUTE, PLAY, EDIT, REC).
// The input sample is registered, then combinational logic updates the
// debounce and mode state and loads the output register, so out_valid rises
// at the clock edge after the one that accepts the input transaction when
// nothing stalls. One sample is taken every cycle while in_stall is low; the
// state update in combinational logic is what sets this rate.
// When the receiver raises out_stall with out_valid high the output holds;
// in_stall is high in every such cycle in which the input register also
// holds a sample, as when samples arrive back to back. No transaction is lost.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data)
// writes debounce_ms at index 0 and hold_ms at index 1; other indexes are
// ignored. cfg_ready is always high.
// Synchronous reset empties both registers, sets the mode to MUTE, the
// debounced level to released, both timestamps to zero and the
// configuration to 20 ms debounce and 1000 ms hold.
module button_debounce_mode_selector_unit
  import bdms_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 pin_level,
  input  logic [TIME_W-1:0]    now_ms,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 pressed,
  output logic [1:0]           mode,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [CFG_W-1:0]  debounce_ms;
  logic [CFG_W-1:0]  hold_ms;

  logic              sample_valid;
  logic              sample_pin;
  logic [TIME_W-1:0] sample_time;

  bdms_state_t       state;
  bdms_state_t       state_next;

  logic              out_free;
  logic              advance;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms <= DEBOUNCE_RESET;
      hold_ms     <= HOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DEBOUNCE: debounce_ms <= cfg_data;
        REG_HOLD:     hold_ms     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid || !out_stall;
  assign advance  = sample_valid && out_free;
  assign in_stall = sample_valid && !out_free;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (!in_stall) begin
      sample_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      sample_pin  <= pin_level;
      sample_time <= now_ms;
    end
  end

  bdms_step u_step (
    .state       (state),
    .pin_level   (sample_pin),
    .now_ms      (sample_time),
    .debounce_ms (debounce_ms),
    .hold_ms     (hold_ms),
    .state_next  (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.stable_level <= 1'b0;
      state.change_time  <= '0;
      state.press_start  <= '0;
      state.active_mode  <= MODE_MUTE;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Output register; it reflects the state just written.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pressed <= state_next.stable_level;
      mode    <= state_next.active_mode;
    end
  end

endmodule

// File: rtl/bdms_checker.sv
// Port-level checks for the button debounce and mode selector, bound to the
// top level. Depends on bdms_pkg.
module bdms_checker
  import bdms_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic                 pressed,
  input logic [1:0]           mode
);

  // Set once any result has shown a mode other than MUTE.
  logic left_mute;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_mute <= 1'b0;
    end else if (out_valid && mode != MODE_MUTE) begin
      left_mute <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pressed) && $stable(mode))
    else $error("stalled output transaction changed");

  a_rec_needs_press: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pressed |-> mode != MODE_REC)
    else $error("REC mode reported with the button released");

  a_no_return_to_mute: assert property (@(posedge clk) disable iff (rst)
    out_valid && left_mute |-> mode != MODE_MUTE)
    else $error("mode returned to MUTE");

  a_free_output_takes_input: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled while the output register is empty");

endmodule

bind button_debounce_mode_selector_unit bdms_checker u_bdms_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .pressed   (pressed),
  .mode      (mode)
);

// File: tb/button_debounce_mode_selector_unit_tb.sv
// Self-checking testbench for button_debounce_mode_selector_unit: a directed
// stimulus table, then randomised press sequences under several register settings.
// Depends on bdms_pkg and the unit under test.
module button_debounce_mode_selector_unit_tb;
  import bdms_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QUIET_LIMIT = 5000;
  localparam int unsigned PHASE_ITEMS = 115;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'd255;

  typedef struct packed {
    logic  pressed;
    mode_t mode;
  } sample_result_t;

  typedef enum logic {ROW_SAMPLE, ROW_CONFIG} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic                  pin;
    logic [TIME_W-1:0]     stamp;
    logic                  typed;
    logic                  want_pressed;
    mode_t                 want_mode;
    logic [CFG_IDX_W-1:0]  reg_sel;
    logic [CFG_W-1:0]      reg_value;
  } plan_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 pin_level = 1'b0;
  logic [TIME_W-1:0]    now_ms = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 pressed;
  logic [1:0]           mode;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // Predicted debouncer and mode state, plus the register copies.
  logic              stable_lvl;
  logic [TIME_W-1:0] change_stamp;
  logic [TIME_W-1:0] press_stamp;
  logic              was_pressed;
  mode_t             model_mode;
  logic [CFG_W-1:0]  debounce_cfg;
  logic [CFG_W-1:0]  hold_cfg;

  sample_result_t expected_results[$];
  plan_row_t      directed_rows[$];
  int unsigned    idle_pct = 0;
  int unsigned    stall_pct = 0;
  int unsigned    fail_count = 0;
  int unsigned    quiet_cycles = 0;

  button_debounce_mode_selector_unit uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .pin_level (pin_level),
    .now_ms    (now_ms),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pressed   (pressed),
    .mode      (mode),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic sample_result_t debounce_and_select(input logic pin,
                                                         input logic [TIME_W-1:0] t);
    sample_result_t    r;
    logic [TIME_W-1:0] gap;
    logic [TIME_W-1:0] held;
    gap = t - change_stamp;
    if (pin != stable_lvl) begin
      if (gap > TIME_W'(debounce_cfg)) begin
        stable_lvl   = pin;
        change_stamp = t;
      end
    end else begin
      change_stamp = t;
    end
    if (stable_lvl && !was_pressed) press_stamp = t;
    held = t - press_stamp;
    // A short release never steps REC; the release rule below returns it to PLAY.
    if (!stable_lvl && was_pressed && held < TIME_W'(hold_cfg)) begin
      case (model_mode)
        MODE_MUTE: model_mode = MODE_PLAY;
        MODE_PLAY: model_mode = MODE_EDIT;
        MODE_EDIT: model_mode = MODE_PLAY;
        default:   model_mode = model_mode;
      endcase
    end
    if (stable_lvl && model_mode != MODE_REC && held >= TIME_W'(hold_cfg))
      model_mode = MODE_REC;
    if (!stable_lvl && model_mode == MODE_REC) model_mode = MODE_PLAY;
    was_pressed = stable_lvl;
    r.pressed = stable_lvl;
    r.mode    = model_mode;
    return r;
  endfunction

  // The valid line stays high between back-to-back transactions; it only drops
  // for a random idle gap or for a register write.
  task automatic send_sample(input logic pin, input logic [TIME_W-1:0] t,
                             input logic typed, input sample_result_t typed_result);
    sample_result_t predicted;
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    in_valid  <= 1'b1;
    pin_level <= pin;
    now_ms    <= t;
    do @(posedge clk); while (in_stall);
    predicted = debounce_and_select(pin, t);
    expected_results.push_back(typed ? typed_result : predicted);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] sel, input logic [CFG_W-1:0] value);
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (sel)
      REG_DEBOUNCE: debounce_cfg = value;
      REG_HOLD:     hold_cfg = value;
      default:      ;
    endcase
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin : check_results
    sample_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: pressed=%0d mode=%0d", pressed, mode);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (pressed !== want.pressed) begin
          $error("pressed: expected %0d, got %0d", want.pressed, pressed);
          fail_count++;
        end
        if (mode !== want.mode) begin
          $error("mode: expected %0d, got %0d", want.mode, mode);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
    begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    sample_result_t    typed_result;
    logic              level;
    logic              pin;
    logic [TIME_W-1:0] stamp;
    logic [CFG_W-1:0]  db_val;
    logic [CFG_W-1:0]  hold_val;
    int unsigned       run_left;
    int unsigned       step_max;

    stable_lvl   = 1'b0;
    change_stamp = '0;
    press_stamp  = '0;
    was_pressed  = 1'b0;
    model_mode   = MODE_MUTE;
    debounce_cfg = DEBOUNCE_RESET;
    hold_cfg     = HOLD_RESET;

    // Short presses walk MUTE, PLAY, EDIT, PLAY; then a hold, a backwards
    // timestamp that releases REC early, a wrap of the timestamp, zero times
    // and the largest register values.
    directed_rows = '{
      '{ROW_SAMPLE, 1'b0, 32'd0,          1'b1, 1'b0, MODE_MUTE, '0, '0},
      '{ROW_SAMPLE, 1'b1, 32'd10,         1'b1, 1'b0, MODE_MUTE, '0, '0},
      '{ROW_SAMPLE, 1'b1, 32'd20,         1'b1, 1'b0, MODE_MUTE, '0, '0},
      '{ROW_SAMPLE, 1'b1, 32'd21,         1'b1, 1'b1, MODE_MUTE, '0, '0},
      '{ROW_SAMPLE, 1'b0, 32'd30,         1'b0, 1'b0, MODE_MUTE, '0, '0},
      '{ROW_SAMPLE, 1'b0, 32'd42,         1'b1, 1'b0, MODE_PLAY, '0, '0},
      '{ROW_SAMPLE, 1'b1, 32'd100,        1'b0, 1'b0, MODE_MUTE, '0, '0},
      '{ROW_SAMPLE, 1'b0, 32'd200,        1'b0, 1'b0, MODE_MUTE, '0, '0},
      '{ROW_SAMPLE, 1'b1, 32'd300,        1'b0, 1'b0, MODE_MUTE, '0, '0},
      '{ROW_SAMPLE, 1'b0, 32'd400,        1'b0, 1'b0, MODE_MUTE, '0, '0},
      '{ROW_SAMPLE, 1'b1, 32'd500,        1'b0, 1'b0, MODE_MUTE, '0, '0},
      '{ROW_SAMPLE, 1'b1, 32'd1500,       1'b0, 1'b0, MODE_MUTE, '0, '0},
      '{ROW_SAMPLE, 1'b0, 32'd2000,       1'b0, 1'b0, MODE_MUTE, '0, '0},
      '{ROW_SAMPLE, 1'b1, 32'd3000,       1'b0, 1'b0, MODE_MUTE, '0, '0},
      '{ROW_SAMPLE, 1'b1, 32'd4000,       1'b0, 1'b0, MODE_MUTE, '0, '0},
      '{ROW_SAMPLE, 1'b0, 32'd3010,       1'b0, 1'b0, MODE_MUTE, '0, '0},
      '{ROW_SAMPLE, 1'b1, 32'hFFFF_FFF0,  1'b0, 1'b0, MODE_MUTE, '0, '0},
      '{ROW_SAMPLE, 1'b0, 32'h0000_0005,  1'b0, 1'b0, MODE_MUTE, '0, '0},
      '{ROW_SAMPLE, 1'b1, 32'hFFFF_FFFF,  1'b0, 1'b0, MODE_MUTE, '0, '0},
      '{ROW_SAMPLE, 1'b0, 32'h0000_0020,  1'b0, 1'b0, MODE_MUTE, '0, '0},
      '{ROW_CONFIG, 1'b0, '0, 1'b0, 1'b0, MODE_MUTE, REG_DEBOUNCE, 16'd0},
      '{ROW_CONFIG, 1'b0, '0, 1'b0, 1'b0, MODE_MUTE, REG_HOLD,     16'd0},
      '{ROW_CONFIG, 1'b0, '0, 1'b0, 1'b0, MODE_MUTE, REG_SPARE,    16'hFFFF},
      '{ROW_SAMPLE, 1'b1, 32'h0000_0020,  1'b0, 1'b0, MODE_MUTE, '0, '0},
      '{ROW_SAMPLE, 1'b1, 32'h0000_0021,  1'b0, 1'b0, MODE_MUTE, '0, '0},
      '{ROW_SAMPLE, 1'b0, 32'h0000_0022,  1'b0, 1'b0, MODE_MUTE, '0, '0},
      '{ROW_CONFIG, 1'b0, '0, 1'b0, 1'b0, MODE_MUTE, REG_DEBOUNCE, 16'hFFFF},
      '{ROW_CONFIG, 1'b0, '0, 1'b0, 1'b0, MODE_MUTE, REG_HOLD,     16'hFFFF},
      '{ROW_SAMPLE, 1'b1, 32'h0001_0021,  1'b0, 1'b0, MODE_MUTE, '0, '0},
      '{ROW_SAMPLE, 1'b1, 32'h0001_0022,  1'b0, 1'b0, MODE_MUTE, '0, '0},
      '{ROW_SAMPLE, 1'b1, 32'h0002_0022,  1'b0, 1'b0, MODE_MUTE, '0, '0}
    };

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    idle_pct  = 26;
    stall_pct = 67;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CONFIG) begin
        write_register(directed_rows[i].reg_sel, directed_rows[i].reg_value);
      end else begin
        typed_result.pressed = directed_rows[i].want_pressed;
        typed_result.mode    = directed_rows[i].want_mode;
        send_sample(directed_rows[i].pin, directed_rows[i].stamp, directed_rows[i].typed,
                    typed_result);
      end
    end

    level    = stable_lvl;
    stamp    = 32'h0002_0022;
    run_left = 0;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          db_val   = 16'($urandom_range(0, 30));
          hold_val = 16'($urandom_range(0, 300));
        end
        1:       begin db_val = 16'd0;     hold_val = 16'd0;     end
        2:       begin db_val = 16'hFFFF;  hold_val = 16'hFFFF;  end
        3: begin
          db_val   = 16'($urandom_range(1, 50));
          hold_val = 16'($urandom_range(100, 2000));
        end
        4:       begin db_val = 16'd0;     hold_val = 16'hFFFF;  end
        default: begin db_val = 16'hFFFF;  hold_val = 16'd0;     end
      endcase
      write_register(REG_DEBOUNCE, db_val);
      write_register(REG_HOLD, hold_val);
      case (phase / 2)
        0:       begin idle_pct = 26; stall_pct = 67; end
        1:       begin idle_pct = 67; stall_pct = 26; end
        default: begin idle_pct = 0;  stall_pct = 0;  end
      endcase
      // Sometimes jump to a random point of the millisecond counter so its wrap may be crossed.
      if ($urandom_range(0, 1) == 0) stamp = $urandom;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Each run holds one intended level for a random span that is sometimes
        // inside the debounce window and sometimes well past the hold time.
        if (run_left == 0) begin
          level    = ~level;
          run_left = $urandom_range(1, 8);
          step_max = (2 * (int'(debounce_cfg) + int'(hold_cfg)) + 8) / run_left;
        end
        run_left--;
        if ($urandom_range(0, 19) == 0) begin
          send_sample(1'($urandom), $urandom, 1'b0, typed_result);
        end else begin
          stamp = stamp + $urandom_range(0, step_max);
          pin   = ($urandom_range(0, 7) == 0) ? ~level : level;
          send_sample(pin, stamp, 1'b0, typed_result);
        end
      end
    end

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: button_debounce_mode_selector_unit.f
rtl/bdms_pkg.sv
rtl/bdms_step.sv
rtl/button_debounce_mode_selector_unit.sv
rtl/bdms_checker.sv
tb/button_debounce_mode_selector_unit_tb.sv
